// ----- design/mlpe_pkg.sv -----
// Package for the monochrome LCD pixel line engine.
// Holds beat types, codes, panel command constants and sequencer states.
// No dependencies.
package mlpe_pkg;

    localparam int DEF_WIDTH  = 128;
    localparam int DEF_HEIGHT = 64;

    // Fixed field widths once a request has passed the range check
    localparam int COL_BITS  = 7;
    localparam int ROW_BITS  = 6;
    localparam int PAGE_BITS = 3;

    localparam logic [7:0] CMD_PAGE    = 8'hB0;
    localparam logic [7:0] CMD_COL_HI  = 8'h10;
    localparam logic [7:0] COL_LO_MASK = 8'h0F;
    localparam logic [7:0] FULL_MASK   = 8'hFF;

    typedef enum logic [1:0] {
        OP_PLOT = 2'd0,
        OP_READ = 2'd1,
        OP_LINE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_READ   = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] column;
        logic [7:0] row;
        logic [7:0] row_end;
        logic       color;
    } in_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] lcd_byte;
        logic       is_data;
        logic       pixel;
        logic       last;
    } out_item_t;

    // Control for the shared read-modify-write unit
    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic [ROW_BITS-1:0]  lo;
        logic [ROW_BITS-1:0]  hi;
        logic                 color;
    } rmw_ctl_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_MODIFY,
        ST_CMD_PAGE,
        ST_CMD_HI,
        ST_CMD_LO,
        ST_DATA,
        ST_ANSWER,
        ST_REJECT
    } state_t;

endpackage

// ----- design/mlpe_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mlpe_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/mlpe_rmw_unit.sv -----
// Shared read-modify-write unit: builds the page mask, merges it into the old
// byte and picks out the addressed pixel. Depends on mlpe_pkg.
module mlpe_rmw_unit (
    input  mlpe_pkg::rmw_ctl_t ctl,
    input  logic [7:0]         old_byte,
    output logic [7:0]         new_byte,
    output logic               pixel
);
    import mlpe_pkg::*;

    logic [7:0] mask;

    always_comb begin
        mask = FULL_MASK;
        // Trim bits above the high end and below the low end on the end pages
        if (ctl.page == ctl.lo[ROW_BITS-1:3]) begin
            mask = mask & (FULL_MASK << ctl.lo[2:0]);
        end
        if (ctl.page == ctl.hi[ROW_BITS-1:3]) begin
            mask = mask & (FULL_MASK >> (~ctl.hi[2:0]));
        end
        new_byte = ctl.color ? (old_byte | mask) : (old_byte & ~mask);
        pixel    = old_byte[ctl.lo[2:0]];
    end

endmodule

// ----- design/mono_lcd_pixel_line_engine_unit.sv -----
// Top level of the monochrome LCD pixel line engine: sequencer, frame store
// and output register. Depends on mlpe_pkg, mlpe_ram and mlpe_rmw_unit.
//
//   channel   dir  handshake          payload
//   s_        in   s_valid / s_ready  s_item  (op, column, row, row_end, color)
//   m_        out  m_valid / m_ready  m_item  (kind, lcd_byte, is_data, pixel, last)
//
// Each page byte is fetched, modified through the shared unit and then sent as
// four panel beats out of the single output register. A line walks its pages
// from low to high; a read answers after the fetch, and a reject answers at once.
// After reset a clearing pass writes zero to every one of the 2**ADDR_W frame store
// entries (ADDR_W is page bits, at least one, plus column bits; 1024 entries by default);
// s_ready stays low meanwhile.
// A stalled m_ready holds the sequencer in its current emit state.
module mono_lcd_pixel_line_engine_unit #(
    parameter int WIDTH  = mlpe_pkg::DEF_WIDTH,
    parameter int HEIGHT = mlpe_pkg::DEF_HEIGHT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mlpe_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output mlpe_pkg::out_item_t m_item
);
    import mlpe_pkg::*;

    localparam int PAGES  = (HEIGHT + 7) / 8;
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int COL_W  = $clog2(WIDTH);
    localparam int ADDR_W = PAGE_W + COL_W;
    localparam int DEPTH  = 2 ** ADDR_W;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]    clr_cnt_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [COL_BITS-1:0]  col_reg;
    logic [ROW_BITS-1:0]  lo_reg;
    logic [ROW_BITS-1:0]  hi_reg;
    logic                 color_reg;
    logic                 is_read_reg;
    logic [7:0]           byte_reg;
    logic                 m_valid_reg;
    out_item_t            m_item_reg;
    out_item_t            m_item_next;

    logic              accept;
    logic              bad_req;
    logic [7:0]        lo_in;
    logic [7:0]        hi_in;
    logic              out_free;
    logic              out_load;
    logic              last_page;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] rw_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;
    rmw_ctl_t          rmw_ctl;
    logic [7:0]        rmw_byte;
    logic              rmw_pixel;

    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign last_page = (page_reg == hi_reg[ROW_BITS-1:3]);
    assign rw_addr   = {page_reg[PAGE_W-1:0], col_reg[COL_W-1:0]};

    always_comb begin
        bad_req = (s_item.column >= 8'(WIDTH)) || (s_item.row >= 8'(HEIGHT));
        if (s_item.op == OP_LINE && s_item.row_end >= 8'(HEIGHT)) begin
            bad_req = 1'b1;
        end
        if (s_item.op != OP_PLOT && s_item.op != OP_READ && s_item.op != OP_LINE) begin
            bad_req = 1'b1;
        end
        lo_in = s_item.row;
        hi_in = s_item.row;
        if (s_item.op == OP_LINE) begin
            if (s_item.row_end < s_item.row) begin
                lo_in = s_item.row_end;
            end else begin
                hi_in = s_item.row_end;
            end
        end
    end

    assign rmw_ctl = '{page: page_reg, lo: lo_reg, hi: hi_reg, color: color_reg};

    mlpe_rmw_unit u_rmw (
        .ctl      (rmw_ctl),
        .old_byte (ram_rdata),
        .new_byte (rmw_byte),
        .pixel    (rmw_pixel)
    );

    mlpe_ram #(
        .DATA_W (8),
        .DEPTH  (DEPTH)
    ) u_frame_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rw_addr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == {ADDR_W{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = bad_req ? ST_REJECT : ST_FETCH;
                end
            end
            ST_FETCH:  state_next = ST_MODIFY;
            ST_MODIFY: state_next = is_read_reg ? ST_ANSWER : ST_CMD_PAGE;
            ST_CMD_PAGE: begin
                if (out_free) state_next = ST_CMD_HI;
            end
            ST_CMD_HI: begin
                if (out_free) state_next = ST_CMD_LO;
            end
            ST_CMD_LO: begin
                if (out_free) state_next = ST_DATA;
            end
            ST_DATA: begin
                if (out_free) state_next = last_page ? ST_IDLE : ST_FETCH;
            end
            ST_ANSWER, ST_REJECT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_ready     = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = rw_addr;
        ram_wdata   = rmw_byte;
        out_load    = 1'b0;
        m_item_next = '{kind: KIND_WRITE, lcd_byte: 8'h00, is_data: 1'b0,
                        pixel: 1'b0, last: 1'b0};
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = 8'h00;
            end
            ST_IDLE:   s_ready = 1'b1;
            ST_FETCH:  ram_re  = 1'b1;
            ST_MODIFY: ram_we  = !is_read_reg;
            ST_CMD_PAGE: begin
                out_load             = out_free;
                m_item_next.lcd_byte = CMD_PAGE | {{(8 - PAGE_BITS){1'b0}}, page_reg};
            end
            ST_CMD_HI: begin
                out_load             = out_free;
                m_item_next.lcd_byte = CMD_COL_HI | {5'b0, col_reg[COL_BITS-1:4]};
            end
            ST_CMD_LO: begin
                out_load             = out_free;
                m_item_next.lcd_byte = {1'b0, col_reg} & COL_LO_MASK;
            end
            ST_DATA: begin
                out_load             = out_free;
                m_item_next.lcd_byte = byte_reg;
                m_item_next.is_data  = 1'b1;
                m_item_next.last     = last_page;
            end
            ST_ANSWER: begin
                out_load          = out_free;
                m_item_next.kind  = KIND_READ;
                m_item_next.pixel = rmw_pixel;
                m_item_next.last  = 1'b1;
            end
            ST_REJECT: begin
                out_load         = out_free;
                m_item_next.kind = KIND_REJECT;
                m_item_next.last = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            col_reg     <= s_item.column[COL_BITS-1:0];
            lo_reg      <= lo_in[ROW_BITS-1:0];
            hi_reg      <= hi_in[ROW_BITS-1:0];
            page_reg    <= lo_in[ROW_BITS-1:3];
            color_reg   <= s_item.color;
            is_read_reg <= (s_item.op == OP_READ);
        end
        if (state_reg == ST_MODIFY) begin
            byte_reg <= rmw_byte;
        end
        // Advance to the next page once its data beat is loaded into the output register
        if (state_reg == ST_DATA && out_free && !last_page) begin
            page_reg <= page_reg + 1'b1;
        end
        if (out_load) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_page_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH) |-> (page_reg <= hi_reg[ROW_BITS-1:3]))
        else $error("page walked past the high end of the run");

    a_accept_goes_on: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_FETCH || state_reg == ST_REJECT))
        else $error("accepted request did not start work");

    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && m_item_next.last) |=> (state_reg == ST_IDLE))
        else $error("final beat loaded but sequencer kept working");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten while a beat waits");

    a_no_write_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MODIFY && is_read_reg) |-> !ram_we)
        else $error("pixel read modified the frame store");

endmodule
